// ----- hdl/pctd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// shared types, codes and constants of the prefix code tree decoder
// ----------------------------------------------------------------------------
package pctd_pkg;

    // defaults of the top level parameters
    localparam int SYMBOL_BITS_DEF = 9;
    localparam int NODE_COUNT_DEF  = 1024;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 2;

    // longest code path walked by an add
    localparam int MAX_CODE_LENGTH = 32;
    // coded bits in one decode chunk (one 16-bit word)
    localparam int CHUNK_BITS = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_DECODE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_PATH = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_STEP,
        S_ADD_NEW,
        S_ADD_WAIT,
        S_DEC_LOAD,
        S_DEC_STEP,
        S_DEC_WAIT,
        S_CLOSE,
        S_REPORT
    } state_t;

    // result event from the walk sequencer to the result stage
    typedef struct packed {
        logic    valid;
        logic    close;      // end of a decode chunk with no result of its own
        logic    fin;        // final result of the transaction
        logic    sym_valid;
        status_t status;
    } evt_t;

endpackage

// ----- hdl/pctd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/pctd_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_out
// result stage: holds one result back until it is known whether it is the last
// ----------------------------------------------------------------------------
module pctd_out
    import pctd_pkg::*;
#(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int OUT_DATA_W  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  evt_t                   evt,
    input  logic [SYMBOL_BITS-1:0] evt_sym,
    output logic                   evt_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    // held result
    logic                   p_valid_reg, p_valid_next;
    logic                   p_fin_reg, p_fin_next;
    logic [SYMBOL_BITS-1:0] p_sym_reg, p_sym_next;
    logic                   p_symv_reg, p_symv_next;
    status_t                p_stat_reg, p_stat_next;
    // output register
    logic                   o_valid_reg, o_valid_next;
    logic                   o_last_reg, o_last_next;
    logic [SYMBOL_BITS-1:0] o_sym_reg, o_sym_next;
    logic                   o_symv_reg, o_symv_next;
    status_t                o_stat_reg, o_stat_next;

    logic o_free, mark, load, move;

    assign o_free    = !o_valid_reg || m_tready;
    assign mark      = evt.valid && evt.close && p_valid_reg && !p_fin_reg;
    assign load      = evt.valid && !mark && (!p_valid_reg || o_free);
    assign move      = p_valid_reg && o_free && (p_fin_reg || load);
    assign evt_ready = mark || !p_valid_reg || o_free;

    always_comb begin
        p_valid_next = p_valid_reg;
        p_fin_next   = p_fin_reg;
        p_sym_next   = p_sym_reg;
        p_symv_next  = p_symv_reg;
        p_stat_next  = p_stat_reg;
        o_valid_next = o_valid_reg;
        o_last_next  = o_last_reg;
        o_sym_next   = o_sym_reg;
        o_symv_next  = o_symv_reg;
        o_stat_next  = o_stat_reg;

        if (move) begin
            o_valid_next = 1'b1;
            o_last_next  = p_fin_reg;
            o_sym_next   = p_sym_reg;
            o_symv_next  = p_symv_reg;
            o_stat_next  = p_stat_reg;
        end else if (m_tready) begin
            o_valid_next = 1'b0;
        end

        if (load) begin
            p_valid_next = 1'b1;
            if (evt.close) begin
                // empty chunk: plain ok result closes the transaction
                p_fin_next  = 1'b1;
                p_sym_next  = '0;
                p_symv_next = 1'b0;
                p_stat_next = STAT_OK;
            end else begin
                p_fin_next  = evt.fin;
                p_sym_next  = evt_sym;
                p_symv_next = evt.sym_valid;
                p_stat_next = evt.status;
            end
        end else if (move) begin
            p_valid_next = 1'b0;
        end

        if (mark) begin
            p_fin_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
        p_fin_reg  <= p_fin_next;
        p_sym_reg  <= p_sym_next;
        p_symv_reg <= p_symv_next;
        p_stat_reg <= p_stat_next;
        o_last_reg <= o_last_next;
        o_sym_reg  <= o_sym_next;
        o_symv_reg <= o_symv_next;
        o_stat_reg <= o_stat_next;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = OUT_DATA_W'({o_stat_reg, o_sym_reg});
    assign m_tuser  = o_symv_reg;
    assign m_tlast  = o_last_reg;

endmodule

// ----- hdl/pctd_walk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_walk
// tree walk sequencer: one node memory access per step for add and decode
// ----------------------------------------------------------------------------
module pctd_walk
    import pctd_pkg::*;
#(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int NODE_BITS   = $clog2(NODE_COUNT),
    parameter int ENTRY_W     = 2 * NODE_BITS + SYMBOL_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input transaction
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FUNC_W-1:0]      func,
    input  logic [CODE_W-1:0]      code_word,
    input  logic [LEN_W-1:0]       code_length,
    input  logic [SYMBOL_BITS-1:0] symbol_in,
    input  logic [CHUNK_BITS-1:0]  chunk,
    // node memory
    output logic                   ram_we,
    output logic [NODE_BITS-1:0]   ram_waddr,
    output logic [ENTRY_W-1:0]     ram_wdata,
    output logic                   ram_re,
    output logic [NODE_BITS-1:0]   ram_raddr,
    input  logic [ENTRY_W-1:0]     ram_rdata,
    // result events
    output evt_t                   evt,
    output logic [SYMBOL_BITS-1:0] evt_sym,
    input  logic                   evt_ready
);

    localparam int NFREE_W = NODE_BITS + 1;
    localparam int BCNT_W  = $clog2(CHUNK_BITS) > 0 ? $clog2(CHUNK_BITS) : 1;

    state_t state_reg, state_next;

    // tree state
    logic [NODE_BITS-1:0]   root_left_reg, root_left_next;
    logic [NODE_BITS-1:0]   root_right_reg, root_right_next;
    logic [NFREE_W-1:0]     free_reg, free_next;
    logic [NODE_BITS-1:0]   walk_reg, walk_next;
    // current node of the walk (children valid when not the root)
    logic [NODE_BITS-1:0]   cur_addr_reg, cur_addr_next;
    logic [NODE_BITS-1:0]   cur_left_reg, cur_left_next;
    logic [NODE_BITS-1:0]   cur_right_reg, cur_right_next;
    logic [SYMBOL_BITS-1:0] cur_sym_reg, cur_sym_next;
    logic [NODE_BITS-1:0]   tgt_reg, tgt_next;
    // per transaction operands
    logic [CODE_W-1:0]      code_reg, code_next;
    logic [LEN_W-1:0]       cnt_reg, cnt_next;
    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic [CHUNK_BITS-1:0]  chunk_reg, chunk_next;
    logic [BCNT_W-1:0]      bcnt_reg, bcnt_next;
    status_t                status_reg, status_next;

    logic [LEN_W-1:0]       len_eff;
    logic                   is_add, bit_sel, at_root, full, leaf, last_bit, add_done;
    logic [NODE_BITS-1:0]   node_left, node_right, child;
    logic [NODE_BITS-1:0]   rd_left, rd_right;
    logic [SYMBOL_BITS-1:0] rd_sym;

    assign len_eff  = (code_length > LEN_W'(MAX_CODE_LENGTH)) ? LEN_W'(MAX_CODE_LENGTH)
                                                              : code_length;
    assign is_add   = (state_reg == S_ADD_STEP);
    assign bit_sel  = is_add ? code_reg[0] : chunk_reg[0];
    assign at_root  = (cur_addr_reg == '0);
    assign node_left  = at_root ? root_left_reg : cur_left_reg;
    assign node_right = at_root ? root_right_reg : cur_right_reg;
    assign child    = bit_sel ? node_right : node_left;
    assign full     = (free_reg == NFREE_W'(NODE_COUNT));
    assign rd_left  = ram_rdata[ENTRY_W-1 -: NODE_BITS];
    assign rd_right = ram_rdata[SYMBOL_BITS +: NODE_BITS];
    assign rd_sym   = ram_rdata[SYMBOL_BITS-1:0];
    assign leaf     = (rd_left == '0) && (rd_right == '0);
    assign last_bit = (bcnt_reg == BCNT_W'(CHUNK_BITS - 1));
    assign add_done = (cnt_reg == LEN_W'(1));
    assign in_ready = (state_reg == S_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    unique case (func)
                        FUNC_CLEAR:  state_next = S_REPORT;
                        FUNC_ADD:    state_next = (len_eff == '0) ? S_REPORT : S_ADD_STEP;
                        FUNC_DECODE: state_next = (walk_reg != '0) ? S_DEC_LOAD : S_DEC_STEP;
                        default:     state_next = S_REPORT;
                    endcase
                end
            end
            S_ADD_STEP: begin
                if (child != '0) begin
                    state_next = S_ADD_WAIT;
                end else if (full) begin
                    state_next = S_REPORT;
                end else begin
                    state_next = S_ADD_NEW;
                end
            end
            S_ADD_NEW, S_ADD_WAIT: begin
                state_next = add_done ? S_REPORT : S_ADD_STEP;
            end
            S_DEC_LOAD: begin
                state_next = S_DEC_STEP;
            end
            S_DEC_STEP: begin
                if (child != '0) begin
                    state_next = S_DEC_WAIT;
                end else if (evt_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_DEC_WAIT: begin
                if (!leaf) begin
                    state_next = last_bit ? S_CLOSE : S_DEC_STEP;
                end else if (evt_ready) begin
                    state_next = last_bit ? S_IDLE : S_DEC_STEP;
                end
            end
            S_CLOSE, S_REPORT: begin
                if (evt_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        free_next       = free_reg;
        walk_next       = walk_reg;
        cur_addr_next   = cur_addr_reg;
        cur_left_next   = cur_left_reg;
        cur_right_next  = cur_right_reg;
        cur_sym_next    = cur_sym_reg;
        tgt_next        = tgt_reg;
        code_next       = code_reg;
        cnt_next        = cnt_reg;
        sym_next        = sym_reg;
        chunk_next      = chunk_reg;
        bcnt_next       = bcnt_reg;
        status_next     = status_reg;

        ram_we    = 1'b0;
        ram_waddr = cur_addr_reg;
        ram_wdata = {node_left, node_right, cur_sym_reg};
        ram_re    = 1'b0;
        ram_raddr = child;

        evt           = '0;
        evt.status    = status_reg;
        evt_sym       = '0;

        unique case (state_reg)
            S_IDLE: begin
                code_next     = code_word;
                cnt_next      = len_eff;
                sym_next      = symbol_in;
                chunk_next    = chunk;
                bcnt_next     = '0;
                status_next   = STAT_OK;
                cur_addr_next = '0;
                if (in_valid) begin
                    unique case (func)
                        FUNC_CLEAR: begin
                            root_left_next  = '0;
                            root_right_next = '0;
                            free_next       = NFREE_W'(1);
                            walk_next       = '0;
                        end
                        FUNC_DECODE: begin
                            // resume at the stored walk position
                            cur_addr_next = walk_reg;
                            ram_re        = (walk_reg != '0);
                            ram_raddr     = walk_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_STEP: begin
                if (child != '0) begin
                    ram_re   = 1'b1;
                    tgt_next = child;
                end else if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    tgt_next  = free_reg[NODE_BITS-1:0];
                    free_next = free_reg + NFREE_W'(1);
                    // link the new node into its parent
                    if (at_root) begin
                        if (bit_sel) begin
                            root_right_next = free_reg[NODE_BITS-1:0];
                        end else begin
                            root_left_next = free_reg[NODE_BITS-1:0];
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = bit_sel ?
                            {cur_left_reg, free_reg[NODE_BITS-1:0], cur_sym_reg} :
                            {free_reg[NODE_BITS-1:0], cur_right_reg, cur_sym_reg};
                    end
                end
            end
            S_ADD_NEW: begin
                ram_we         = 1'b1;
                ram_waddr      = tgt_reg;
                ram_wdata      = {{(2 * NODE_BITS){1'b0}}, sym_reg};
                cur_addr_next  = tgt_reg;
                cur_left_next  = '0;
                cur_right_next = '0;
                cur_sym_next   = sym_reg;
                code_next      = code_reg >> 1;
                cnt_next       = cnt_reg - LEN_W'(1);
            end
            S_ADD_WAIT: begin
                cur_addr_next  = tgt_reg;
                cur_left_next  = rd_left;
                cur_right_next = rd_right;
                cur_sym_next   = rd_sym;
                code_next      = code_reg >> 1;
                cnt_next       = cnt_reg - LEN_W'(1);
            end
            S_DEC_LOAD: begin
                cur_left_next  = rd_left;
                cur_right_next = rd_right;
            end
            S_DEC_STEP: begin
                if (child != '0) begin
                    ram_re   = 1'b1;
                    tgt_next = child;
                end else begin
                    // missing child: stop the chunk, position kept
                    evt.valid  = 1'b1;
                    evt.fin    = 1'b1;
                    evt.status = STAT_BAD_PATH;
                end
            end
            S_DEC_WAIT: begin
                if (leaf) begin
                    evt.valid     = 1'b1;
                    evt.fin       = last_bit;
                    evt.sym_valid = 1'b1;
                    evt.status    = STAT_OK;
                    evt_sym       = rd_sym;
                    if (evt_ready) begin
                        walk_next     = '0;
                        cur_addr_next = '0;
                        chunk_next    = chunk_reg >> 1;
                        bcnt_next     = bcnt_reg + BCNT_W'(1);
                    end
                end else begin
                    walk_next      = tgt_reg;
                    cur_addr_next  = tgt_reg;
                    cur_left_next  = rd_left;
                    cur_right_next = rd_right;
                    chunk_next     = chunk_reg >> 1;
                    bcnt_next      = bcnt_reg + BCNT_W'(1);
                end
            end
            S_CLOSE: begin
                evt.valid = 1'b1;
                evt.close = 1'b1;
                evt.fin   = 1'b1;
            end
            S_REPORT: begin
                evt.valid = 1'b1;
                evt.fin   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            free_reg       <= NFREE_W'(1);
            walk_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            free_reg       <= free_next;
            walk_reg       <= walk_next;
        end
        cur_addr_reg  <= cur_addr_next;
        cur_left_reg  <= cur_left_next;
        cur_right_reg <= cur_right_next;
        cur_sym_reg   <= cur_sym_next;
        tgt_reg       <= tgt_next;
        code_reg      <= code_next;
        cnt_reg       <= cnt_next;
        sym_reg       <= sym_next;
        chunk_reg     <= chunk_next;
        bcnt_reg      <= bcnt_next;
        status_reg    <= status_next;
    end

endmodule

// ----- hdl/prefix_code_tree_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder
// binary prefix code tree in a node memory: clear, add code word, decode chunk
// ----------------------------------------------------------------------------
// the block takes one transaction at a time and drops s_tready until the
// transaction's results are handed to the result stage. each tree step splits
// into an access and a follow-up state because the node memory read data is
// registered: a clear or an unused function code only reports, an add steps
// once per code bit (a memory read and wait for an existing node, a parent
// link write and a node write for a new one), and a decode at most once per
// chunk bit, after an extra load when the walk resumes below the root. a result
// stalled on m_tready stalls the walk only when a second result already waits
// behind it in the result stage. the root lives in flip-flops and the other
// nodes are written before they are read, so no clearing pass follows reset.
module prefix_code_tree_decoder
    import pctd_pkg::*;
#(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int IN_DATA_W   = ((CODE_W + LEN_W + SYMBOL_BITS + CHUNK_BITS + 7) / 8) * 8,
    parameter int OUT_DATA_W  = ((SYMBOL_BITS + STATUS_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input transactions
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // code_word, code_length, symbol_in, chunk, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic [FUNC_W-1:0]     s_tuser,
    // result transactions
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // symbol_out, status, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // symbol_valid
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int NODE_BITS = $clog2(NODE_COUNT);
    localparam int ENTRY_W   = 2 * NODE_BITS + SYMBOL_BITS;

    // input field unpacking
    logic [CODE_W-1:0]      code_word;
    logic [LEN_W-1:0]       code_length;
    logic [SYMBOL_BITS-1:0] symbol_in;
    logic [CHUNK_BITS-1:0]  chunk;

    assign code_word   = s_tdata[CODE_W-1:0];
    assign code_length = s_tdata[CODE_W +: LEN_W];
    assign symbol_in   = s_tdata[CODE_W + LEN_W +: SYMBOL_BITS];
    assign chunk       = s_tdata[CODE_W + LEN_W + SYMBOL_BITS +: CHUNK_BITS];

    // node memory port
    logic                 ram_we, ram_re;
    logic [NODE_BITS-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

    // result events
    evt_t                   evt;
    logic [SYMBOL_BITS-1:0] evt_sym;
    logic                   evt_ready;

    // node store: {left child, right child, symbol}, child 0 means none
    pctd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer walking the tree one node per step
    pctd_walk #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .NODE_COUNT  (NODE_COUNT),
        .NODE_BITS   (NODE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .func        (s_tuser),
        .code_word   (code_word),
        .code_length (code_length),
        .symbol_in   (symbol_in),
        .chunk       (chunk),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .evt         (evt),
        .evt_sym     (evt_sym),
        .evt_ready   (evt_ready)
    );

    // result stage: one held result plus the output register
    pctd_out #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .OUT_DATA_W  (OUT_DATA_W)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt       (evt),
        .evt_sym   (evt_sym),
        .evt_ready (evt_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- hdl/pctd_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_check
// port level checks of the prefix code tree decoder, bound to the top level
// ----------------------------------------------------------------------------
module pctd_check
    import pctd_pkg::*;
#(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int OUT_DATA_W  = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // one transaction at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // a decoded symbol always comes with ok status
    a_sym_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[SYMBOL_BITS +: STATUS_W] == STAT_OK)
        else $error("symbol with error status");

    // no symbol bits without a symbol
    a_sym_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[SYMBOL_BITS-1:0] == '0)
        else $error("symbol field set without symbol");

    // an error ends the transaction
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[SYMBOL_BITS +: STATUS_W] != STAT_OK) |-> m_tlast)
        else $error("error result not last");

endmodule

bind prefix_code_tree_decoder pctd_check #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .OUT_DATA_W  (OUT_DATA_W)
) u_pctd_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
